/* rtl/core/fsd_pkg.sv */
// fsd_pkg: shared types and constants for the Floyd-Steinberg dither unit.
// No dependencies; used by every module under rtl/core except fsd_ram.
`timescale 1ns / 1ps

package fsd_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W = 8;
    localparam int THR_W    = 8;
    localparam int LW_W     = 11;
    localparam int ERR_W    = 10;   // signed error word held in the line store
    localparam int CORR_W   = 11;   // signed corrected sum before clamping
    localparam int DIFF_W   = 9;    // signed corrected minus output

    // Queue between front and back, and the write log that covers its depth.
    // Up to two line store writes per item in flight, plus one pending.
    localparam int Q_DEPTH    = 2;
    localparam int HIST_DEPTH = 2 * (Q_DEPTH + 1) + 2;

    // Levels and diffusion weights (sixteenths)
    localparam logic [SAMPLE_W-1:0] LEVEL_WHITE = 8'hFF;
    localparam logic [SAMPLE_W-1:0] LEVEL_BLACK = 8'h00;
    localparam logic [2:0] WEIGHT_RIGHT       = 3'd7;
    localparam logic [2:0] WEIGHT_BELOW_LEFT  = 3'd3;
    localparam logic [2:0] WEIGHT_BELOW       = 3'd5;
    localparam logic [2:0] WEIGHT_BELOW_RIGHT = 3'd1;

    // Configuration register map and reset values
    typedef enum logic [0:0] {
        CFG_THRESHOLD  = 1'b0,
        CFG_LINE_WIDTH = 1'b1
    } t_cfg_idx;

    localparam logic [THR_W-1:0] THRESHOLD_RST  = 8'd127;
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd640;

    // Classified pixel passed from front to back (column travels beside it)
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
        logic                first_row;
        logic                last;
    } t_pix;

endpackage

/* rtl/core/fsd_ram.sv */
// fsd_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-cycle write. No dependencies.
`timescale 1ns / 1ps

module fsd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fsd_queue.sv */
// fsd_queue: short register FIFO between the front and the back.
// Depends on fsd_pkg (depth).
`timescale 1ns / 1ps

module fsd_queue #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = (fsd_pkg::Q_DEPTH > 1) ? $clog2(fsd_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(fsd_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] r_data [fsd_pkg::Q_DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CW'(fsd_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_data[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers wrap at the queue depth
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] res;
        res = (p == PW'(fsd_pkg::Q_DEPTH - 1)) ? '0 : p + PW'(1);
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/core/fsd_front.sv */
// fsd_front: accepts pixels, tracks column and first row, issues the line store read.
// Depends on fsd_pkg; drives the read port of fsd_ram and feeds fsd_queue.
`timescale 1ns / 1ps

module fsd_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [fsd_pkg::LW_W-1:0]            i_line_width,
    // pixel input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [fsd_pkg::SAMPLE_W-1:0]        i_grey_sample,
    input  logic                                i_frame_start,
    // line store read port
    output logic                                o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_rd_addr,
    input  logic [fsd_pkg::ERR_W-1:0]           i_rd_data,
    // towards the queue
    output logic                                o_q_valid,
    input  logic                                i_q_ready,
    output fsd_pkg::t_pix                       o_q_item,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_q_col,
    output logic [fsd_pkg::ERR_W-1:0]           o_q_err
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = (AW + 1 > fsd_pkg::LW_W) ? AW + 1 : fsd_pkg::LW_W;

    logic [AW-1:0]  r_col;
    logic           r_first;
    logic           r_s_vld;
    fsd_pkg::t_pix  r_s_item;
    logic [AW-1:0]  r_s_col;

    logic           accept;
    logic [AW-1:0]  col, n_col;
    logic           first, last;
    logic [EW-1:0]  lw_ext, width_eff;

    assign o_in_ready = !r_s_vld || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Column classification: frame start restarts, width clamped to 1..MAX_WIDTH
    always_comb begin
        col    = i_frame_start ? '0 : r_col;
        first  = i_frame_start || r_first;
        lw_ext = EW'(i_line_width);
        priority if (lw_ext == '0) begin
            width_eff = EW'(1);
        end else if (lw_ext > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = lw_ext;
        end
        last  = (EW'(col) >= width_eff - EW'(1));
        n_col = last ? '0 : col + AW'(1);
    end

    // Read the pending error of this column; data lands with the stage register
    assign o_rd_en   = accept;
    assign o_rd_addr = col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
            r_s_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_col   <= n_col;
                r_first <= first && !last;
                r_s_vld <= 1'b1;
            end else if (i_q_ready) begin
                r_s_vld <= 1'b0;
            end
        end
    end

    // Stage payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_item.sample      <= i_grey_sample;
            r_s_item.frame_start <= i_frame_start;
            r_s_item.first_row   <= first;
            r_s_item.last        <= last;
            r_s_col              <= col;
        end
    end

    assign o_q_valid = r_s_vld;
    assign o_q_item  = r_s_item;
    assign o_q_col   = r_s_col;
    assign o_q_err   = i_rd_data;

endmodule

/* rtl/core/fsd_back.sv */
// fsd_back: error correction, threshold, diffusion and line store writes.
// Depends on fsd_pkg; pops fsd_queue and drives the write port of fsd_ram.
`timescale 1ns / 1ps

module fsd_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [fsd_pkg::THR_W-1:0]           i_threshold,
    // from the queue
    input  logic                                i_q_valid,
    output logic                                o_q_ready,
    input  fsd_pkg::t_pix                       i_q_item,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_q_col,
    input  logic [fsd_pkg::ERR_W-1:0]           i_q_err,
    // line store write port
    output logic                                o_we,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_waddr,
    output logic [fsd_pkg::ERR_W-1:0]           o_wdata,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fsd_pkg::SAMPLE_W-1:0]        o_out_level,
    output logic                                o_row_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = fsd_pkg::ERR_W;
    localparam int DW = fsd_pkg::DIFF_W;
    localparam int CW = fsd_pkg::CORR_W;
    localparam int HD = fsd_pkg::HIST_DEPTH;

    // Diffusion state
    logic [EW-1:0]  r_right, r_pa, r_pb;
    // Below sum of a row's last column, written on the following cycle
    logic           r_pend_vld;
    logic [AW-1:0]  r_pend_addr;
    logic [EW-1:0]  r_pend_data;
    // Log of recent line store writes, entry 0 newest
    logic [HD-1:0]  r_h_vld;
    logic [AW-1:0]  r_h_addr [HD];
    logic [EW-1:0]  r_h_data [HD];
    // Output register
    logic                          r_out_vld;
    logic [fsd_pkg::SAMPLE_W-1:0]  r_out_level;
    logic                          r_row_end;

    logic                          pop;
    logic [EW-1:0]                 fwd, nre, re, pa, pb;
    logic [CW-1:0]                 corr;
    logic [fsd_pkg::SAMPLE_W-1:0]  clamped, level;
    logic [DW-1:0]                 err;
    logic [EW-1:0]                 s_right, s_bl, s_b, s_br;
    logic [EW-1:0]                 a_data, n_pa;
    logic                          a_we;
    logic [AW-1:0]                 a_addr;

    // k/16 share of the error, truncated toward zero
    function automatic logic [EW-1:0] share(input logic [DW-1:0] e, input logic [2:0] k);
        logic [12:0] p;
        logic [12:0] adj;
        p   = {{(13 - DW){e[DW-1]}}, e} * {10'd0, k};
        adj = p[12] ? p + 13'd15 : p;
        return {{(EW - 9){adj[12]}}, adj[12:4]};
    endfunction

    assign o_q_ready = !r_out_vld || i_out_ready;
    assign pop       = i_q_valid && o_q_ready;

    // Line store value: newest logged write to this column wins over the read data
    always_comb begin
        fwd = i_q_err;
        for (int k = HD - 1; k >= 0; k--) begin
            if (r_h_vld[k] && (r_h_addr[k] == i_q_col)) begin
                fwd = r_h_data[k];
            end
        end
        if (r_pend_vld && (r_pend_addr == i_q_col)) begin
            fwd = r_pend_data;
        end
    end

    // Correct, clamp, threshold
    always_comb begin
        re   = i_q_item.frame_start ? '0 : r_right;
        pa   = i_q_item.frame_start ? '0 : r_pa;
        pb   = i_q_item.frame_start ? '0 : r_pb;
        nre  = i_q_item.first_row ? '0 : fwd;
        corr = CW'(i_q_item.sample)
             + {{(CW - EW){re[EW-1]}}, re}
             + {{(CW - EW){nre[EW-1]}}, nre};
        priority if (corr[CW-1]) begin
            clamped = fsd_pkg::LEVEL_BLACK;
        end else if (corr[CW-2:fsd_pkg::SAMPLE_W] != '0) begin
            clamped = fsd_pkg::LEVEL_WHITE;
        end else begin
            clamped = corr[fsd_pkg::SAMPLE_W-1:0];
        end
        level = (clamped > i_threshold) ? fsd_pkg::LEVEL_WHITE : fsd_pkg::LEVEL_BLACK;
        err   = {1'b0, clamped} - {1'b0, level};
    end

    // Diffusion shares and the completed below-left column
    always_comb begin
        s_right = share(err, fsd_pkg::WEIGHT_RIGHT);
        s_bl    = share(err, fsd_pkg::WEIGHT_BELOW_LEFT);
        s_b     = share(err, fsd_pkg::WEIGHT_BELOW);
        s_br    = share(err, fsd_pkg::WEIGHT_BELOW_RIGHT);
        a_data  = pa + s_bl;
        n_pa    = pb + s_b;
        a_we    = pop && (i_q_col != '0);
        a_addr  = i_q_col - AW'(1);
    end

    // The pixel after a row end sits in column zero, so the two never collide
    assign o_we    = r_pend_vld || a_we;
    assign o_waddr = r_pend_vld ? r_pend_addr : a_addr;
    assign o_wdata = r_pend_vld ? r_pend_data : a_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right    <= '0;
            r_pa       <= '0;
            r_pb       <= '0;
            r_pend_vld <= 1'b0;
            r_h_vld    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_pend_vld <= pop && i_q_item.last;
            if (pop) begin
                if (i_q_item.last) begin
                    r_right <= '0;
                    r_pa    <= '0;
                    r_pb    <= '0;
                end else begin
                    r_right <= s_right;
                    r_pa    <= n_pa;
                    r_pb    <= s_br;
                end
            end
            if (o_we) begin
                r_h_vld <= {r_h_vld[HD-2:0], 1'b1};
            end
            if (pop) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (pop && i_q_item.last) begin
            r_pend_addr <= i_q_col;
            r_pend_data <= n_pa;
        end
        if (o_we) begin
            r_h_addr[0] <= o_waddr;
            r_h_data[0] <= o_wdata;
            for (int k = 1; k < HD; k++) begin
                r_h_addr[k] <= r_h_addr[k-1];
                r_h_data[k] <= r_h_data[k-1];
            end
        end
        if (pop) begin
            r_out_level <= level;
            r_row_end   <= i_q_item.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_level = r_out_level;
    assign o_row_end   = r_row_end;

endmodule

/* rtl/core/floyd_steinberg_dither_unit.sv */
// floyd_steinberg_dither_unit: top level of the Floyd-Steinberg error diffusion ditherer.
// Depends on fsd_pkg, fsd_ram, fsd_queue, fsd_front and fsd_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   pixel in | i_in_valid / o_in_ready   | i_grey_sample[7:0], i_frame_start
//   result   | o_out_valid / i_out_ready | o_out_level[7:0], o_row_end
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_index[0:0], i_cfg_data[10:0]
//
// One pixel per clock sustained while the result output is not stalled; the bound is the
// back's loop in which a pixel's right share feeds the next pixel's correction.
// A result passes the front stage register, the queue and the output register.
// Synchronous active-low reset clears control state; the line store is not cleared
// and line store data is ignored in the first row of a frame.
// A stalled result output fills the output register, then the two-entry queue,
// then the front stage, after which o_in_ready drops. Config is always ready.
`timescale 1ns / 1ps

module floyd_steinberg_dither_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fsd_pkg::SAMPLE_W-1:0]      i_grey_sample,
    input  logic                              i_frame_start,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fsd_pkg::SAMPLE_W-1:0]      o_out_level,
    output logic                              o_row_end,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [0:0]                        i_cfg_index,
    input  logic [fsd_pkg::LW_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = AW + fsd_pkg::ERR_W + $bits(fsd_pkg::t_pix);

    logic [fsd_pkg::THR_W-1:0] r_threshold;
    logic [fsd_pkg::LW_W-1:0]  r_line_width;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [fsd_pkg::ERR_W-1:0]  rd_data;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [fsd_pkg::ERR_W-1:0]  ram_wdata;

    logic                       f_valid, f_ready;
    fsd_pkg::t_pix              f_item;
    logic [AW-1:0]              f_col;
    logic [fsd_pkg::ERR_W-1:0]  f_err;

    logic                       b_valid, b_ready;
    fsd_pkg::t_pix              b_item;
    logic [AW-1:0]              b_col;
    logic [fsd_pkg::ERR_W-1:0]  b_err;
    logic [QW-1:0]              q_in, q_out;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= fsd_pkg::THRESHOLD_RST;
            r_line_width <= fsd_pkg::LINE_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (fsd_pkg::t_cfg_idx'(i_cfg_index))
                fsd_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[fsd_pkg::THR_W-1:0];
                end
                fsd_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Line store of next-row errors
    fsd_ram #(
        .WIDTH (fsd_pkg::ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    fsd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_width  (r_line_width),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_grey_sample (i_grey_sample),
        .i_frame_start (i_frame_start),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_q_valid     (f_valid),
        .i_q_ready     (f_ready),
        .o_q_item      (f_item),
        .o_q_col       (f_col),
        .o_q_err       (f_err)
    );

    assign q_in = {f_col, f_err, f_item};
    assign {b_col, b_err, b_item} = q_out;

    fsd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (q_in),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (q_out)
    );

    fsd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_q_valid   (b_valid),
        .o_q_ready   (b_ready),
        .i_q_item    (b_item),
        .i_q_col     (b_col),
        .i_q_err     (b_err),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_level (o_out_level),
        .o_row_end   (o_row_end)
    );

    // Results are two-level only
    a_level_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_level == fsd_pkg::LEVEL_WHITE ||
                         o_out_level == fsd_pkg::LEVEL_BLACK))
        else $error("dither output not two-level");

    // Line store writes stay inside the store
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(ram_waddr) < MAX_WIDTH))
        else $error("line store write out of range");

    // A blocked front stage must hold off new pixel beats
    a_front_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && !f_ready) |-> !o_in_ready)
        else $error("pixel accepted while front stage blocked");

    // Nothing leaves the block in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule
